// ===== hw/rtl/slpi_pkg.sv =====
// Shared types, constants and helper functions for the straight-line point interpolator.
// Used by the front, queue, back and top-level modules. Has no dependencies.
package slpi_pkg;

   localparam int CORDIC_W  = 48;   // CORDIC datapath width
   localparam int ACC_W     = 46;   // point accumulator width (Q32.14, bits 45:14 are output)
   localparam int STEP_CW   = 6;    // width of the intermediate point count
   localparam int ATAN_IW   = 5;    // arctangent table index width
   localparam int PROD_W    = 64;

   localparam logic [15:0] KINV_HI = 16'd39796;
   localparam logic [15:0] KINV_LO = 16'd60840;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_MID   = 2'd1,
      KIND_GOAL  = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      FR_IDLE, FR_ROT, FR_LMUL, FR_LSUM, FR_CHK, FR_COUNT,
      FR_OROT, FR_OMUL, FR_OSUM, FR_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE, BK_START, BK_MID, BK_GOAL
   } back_state_type;

   typedef struct packed {
      logic signed [31:0]      start_x;
      logic signed [31:0]      start_y;
      logic signed [15:0]      start_heading;
      logic signed [31:0]      goal_x;
      logic signed [31:0]      goal_y;
      logic signed [15:0]      goal_heading;
      logic        [15:0]      seg_heading;
      logic signed [ACC_W-1:0] ofs_x;
      logic signed [ACC_W-1:0] ofs_y;
      logic        [STEP_CW-1:0] steps;
      logic                    truncated;
      logic                    too_close;
   } job_type;

   // Arctangent of 2^-i in binary angle units, rounded.
   function automatic logic [15:0] atan_unit(input logic [ATAN_IW-1:0] idx);
      logic [15:0] r;
      unique case (idx)
         5'd0:  r = 16'd8192;
         5'd1:  r = 16'd4836;
         5'd2:  r = 16'd2555;
         5'd3:  r = 16'd1297;
         5'd4:  r = 16'd651;
         5'd5:  r = 16'd326;
         5'd6:  r = 16'd163;
         5'd7:  r = 16'd81;
         5'd8:  r = 16'd41;
         5'd9:  r = 16'd20;
         5'd10: r = 16'd10;
         5'd11: r = 16'd5;
         5'd12: r = 16'd3;
         5'd13: r = 16'd1;
         5'd14: r = 16'd1;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

   // Second half of the gain removal: (m*hi + (m*lo >> 16)) >> 16.
   function automatic logic [CORDIC_W-1:0] kinv_sum(input logic [PROD_W-1:0] hi_prod,
                                                    input logic [PROD_W-1:0] lo_prod);
      logic [PROD_W-1:0] s;
      s = hi_prod + (lo_prod >> 16);
      return s[CORDIC_W+15:16];
   endfunction

endpackage

// ===== hw/rtl/slpi_front.sv =====
// Front end: accepts a segment, runs CORDIC vectoring, length gain removal, step count
// and offset rotation, then pushes a finished job into the queue. Uses slpi_pkg.
module slpi_front import slpi_pkg::*; #(
   parameter int MAX_STEPS         = 62,
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          seg_valid,
   output logic          seg_ready,
   input  logic [159:0]  seg_data,
   input  logic [30:0]   step_interval,
   output logic          job_valid,
   input  logic          job_ready,
   output job_type       job
);

   localparam int ITER_W = $clog2(CORDIC_ITERATIONS);

   front_state_type state_ff, state_in;
   logic signed [CORDIC_W-1:0] vx_ff, vx_in, vy_ff, vy_in;
   logic [15:0]                z_ff, z_in;
   logic                       flip_ff, flip_in;
   logic [CORDIC_ITERATIONS-1:0] dirs_ff, dirs_in;
   logic [ITER_W-1:0]          iter_ff, iter_in;
   logic [PROD_W-1:0]          pa_hi_ff, pa_hi_in, pa_lo_ff, pa_lo_in;
   logic [PROD_W-1:0]          pb_hi_ff, pb_hi_in, pb_lo_ff, pb_lo_in;
   logic                       neg_u_ff, neg_u_in, neg_v_ff, neg_v_in;
   logic [CORDIC_W-1:0]        len_ff, len_in, acc_ff, acc_in;
   logic [STEP_CW-1:0]         k_ff, k_in;
   logic                       trunc_ff, trunc_in, close_ff, close_in;
   job_type                    seg_ff, seg_in;

   logic signed [32:0]         dx, dy;
   logic signed [CORDIC_W-1:0] sx0, sy0, sh_x, sh_y;
   logic [CORDIC_W-1:0]        s24, mag_a, mag_b, sum_a, sum_b;
   logic                       last_iter;

   assign seg_ready = (state_ff == FR_IDLE);
   assign job_valid = (state_ff == FR_PUSH);
   assign job       = seg_ff;

   assign s24       = {{(CORDIC_W-39){1'b0}}, step_interval, 8'd0};
   assign sh_x      = vx_ff >>> iter_ff;
   assign sh_y      = vy_ff >>> iter_ff;
   assign last_iter = (iter_ff == ITER_W'(CORDIC_ITERATIONS - 1));
   assign sum_a     = kinv_sum(pa_hi_ff, pa_lo_ff);
   assign sum_b     = kinv_sum(pb_hi_ff, pb_lo_ff);

   always_comb begin
      dx  = {seg_data[111], seg_data[111:80]} - {seg_data[31], seg_data[31:0]};
      dy  = {seg_data[143], seg_data[143:112]} - {seg_data[63], seg_data[63:32]};
      sx0 = {{(CORDIC_W-41){dx[32]}}, dx, 8'd0};
      sy0 = {{(CORDIC_W-41){dy[32]}}, dy, 8'd0};
      mag_a = vx_ff[CORDIC_W-1] ? CORDIC_W'(-vx_ff) : vx_ff;
      mag_b = vy_ff[CORDIC_W-1] ? CORDIC_W'(-vy_ff) : vy_ff;
   end

   always_comb begin
      state_in = state_ff;
      vx_in = vx_ff;  vy_in = vy_ff;  z_in = z_ff;  flip_in = flip_ff;
      dirs_in = dirs_ff;  iter_in = iter_ff;
      pa_hi_in = pa_hi_ff;  pa_lo_in = pa_lo_ff;  pb_hi_in = pb_hi_ff;  pb_lo_in = pb_lo_ff;
      neg_u_in = neg_u_ff;  neg_v_in = neg_v_ff;
      len_in = len_ff;  acc_in = acc_ff;  k_in = k_ff;
      trunc_in = trunc_ff;  close_in = close_ff;
      seg_in = seg_ff;
      unique case (state_ff)
         FR_IDLE: begin
            if (seg_valid) begin
               seg_in.start_x       = seg_data[31:0];
               seg_in.start_y       = seg_data[63:32];
               seg_in.start_heading = seg_data[79:64];
               seg_in.goal_x        = seg_data[111:80];
               seg_in.goal_y        = seg_data[143:112];
               seg_in.goal_heading  = seg_data[159:144];
               // A vector pointing left is turned by pi first.
               flip_in = dx[32];
               vx_in   = dx[32] ? CORDIC_W'(-sx0) : sx0;
               vy_in   = dx[32] ? CORDIC_W'(-sy0) : sy0;
               z_in    = dx[32] ? 16'h8000 : 16'h0000;
               iter_in = '0;
               state_in = FR_ROT;
            end
         end
         FR_ROT: begin
            if (!vy_ff[CORDIC_W-1]) begin
               vx_in = vx_ff + sh_y;
               vy_in = vy_ff - sh_x;
               z_in  = z_ff + atan_unit(ATAN_IW'(iter_ff));
               dirs_in[iter_ff] = 1'b1;
            end else begin
               vx_in = vx_ff - sh_y;
               vy_in = vy_ff + sh_x;
               z_in  = z_ff - atan_unit(ATAN_IW'(iter_ff));
               dirs_in[iter_ff] = 1'b0;
            end
            iter_in = iter_ff + 1'b1;
            if (last_iter) begin
               state_in = FR_LMUL;
            end
         end
         FR_LMUL: begin
            // A negative x after vectoring counts as zero length.
            pa_hi_in = PROD_W'(vx_ff[CORDIC_W-1] ? '0 : vx_ff) * PROD_W'(KINV_HI);
            pa_lo_in = PROD_W'(vx_ff[CORDIC_W-1] ? '0 : vx_ff) * PROD_W'(KINV_LO);
            state_in = FR_LSUM;
         end
         FR_LSUM: begin
            len_in   = sum_a;
            state_in = FR_CHK;
         end
         FR_CHK: begin
            k_in     = '0;
            acc_in   = s24;
            trunc_in = 1'b0;
            seg_in.seg_heading = z_ff;
            if (len_ff < s24) begin
               close_in = 1'b1;
               seg_in.too_close = 1'b1;
               seg_in.truncated = 1'b0;
               state_in = FR_PUSH;
            end else begin
               close_in = 1'b0;
               state_in = FR_COUNT;
            end
         end
         FR_COUNT: begin
            // acc holds (k + 1) times the interval.
            if (k_ff != STEP_CW'(MAX_STEPS) && acc_ff < len_ff) begin
               k_in   = k_ff + 1'b1;
               acc_in = acc_ff + s24;
            end else begin
               trunc_in = (k_ff == STEP_CW'(MAX_STEPS)) && (acc_ff < len_ff);
               vx_in    = {{(CORDIC_W-45){1'b0}}, step_interval, 14'd0};
               vy_in    = '0;
               iter_in  = '0;
               state_in = FR_OROT;
            end
         end
         FR_OROT: begin
            // Replay the vectoring directions on (interval, 0).
            if (dirs_ff[iter_ff]) begin
               vx_in = vx_ff - sh_y;
               vy_in = vy_ff + sh_x;
            end else begin
               vx_in = vx_ff + sh_y;
               vy_in = vy_ff - sh_x;
            end
            iter_in = iter_ff + 1'b1;
            if (last_iter) begin
               state_in = FR_OMUL;
            end
         end
         FR_OMUL: begin
            neg_u_in = vx_ff[CORDIC_W-1] ^ flip_ff;
            neg_v_in = vy_ff[CORDIC_W-1] ^ flip_ff;
            pa_hi_in = PROD_W'(mag_a) * PROD_W'(KINV_HI);
            pa_lo_in = PROD_W'(mag_a) * PROD_W'(KINV_LO);
            pb_hi_in = PROD_W'(mag_b) * PROD_W'(KINV_HI);
            pb_lo_in = PROD_W'(mag_b) * PROD_W'(KINV_LO);
            state_in = FR_OSUM;
         end
         FR_OSUM: begin
            seg_in.ofs_x     = neg_u_ff ? ACC_W'(-sum_a) : ACC_W'(sum_a);
            seg_in.ofs_y     = neg_v_ff ? ACC_W'(-sum_b) : ACC_W'(sum_b);
            seg_in.steps     = k_ff;
            seg_in.truncated = trunc_ff;
            seg_in.too_close = close_ff;
            state_in = FR_PUSH;
         end
         FR_PUSH: begin
            if (job_ready) begin
               state_in = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      vx_ff <= vx_in;  vy_ff <= vy_in;  z_ff <= z_in;  flip_ff <= flip_in;
      dirs_ff <= dirs_in;  iter_ff <= iter_in;
      pa_hi_ff <= pa_hi_in;  pa_lo_ff <= pa_lo_in;  pb_hi_ff <= pb_hi_in;  pb_lo_ff <= pb_lo_in;
      neg_u_ff <= neg_u_in;  neg_v_ff <= neg_v_in;
      len_ff <= len_in;  acc_ff <= acc_in;  k_ff <= k_in;
      trunc_ff <= trunc_in;  close_ff <= close_in;
      seg_ff <= seg_in;
   end

endmodule

// ===== hw/rtl/slpi_queue.sv =====
// Two-entry job queue between the front end and the point emitter.
// Uses job_type from slpi_pkg.
module slpi_queue import slpi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== hw/rtl/slpi_back.sv =====
// Back end: takes a job from the queue and emits start, intermediate and goal points
// through a registered output stage. Uses slpi_pkg.
module slpi_back import slpi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   output logic        job_ready,
   input  job_type     job,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,
   output logic [3:0]  rsp_tuser,
   output logic        rsp_tlast
);

   back_state_type          state_ff, state_in;
   job_type                 job_ff, job_in;
   logic signed [ACC_W-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic [STEP_CW-1:0]      cnt_ff, cnt_in;
   logic                    valid_ff, valid_in;
   logic [79:0]             data_ff, data_in;
   logic [3:0]              user_ff, user_in;
   logic                    last_ff, last_in;
   logic                    load_ok;
   logic signed [ACC_W-1:0] ax_next, ay_next;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;
   assign job_ready  = (state_ff == BK_IDLE);
   assign load_ok    = !valid_ff || rsp_tready;
   assign ax_next    = ax_ff + job_ff.ofs_x;
   assign ay_next    = ay_ff + job_ff.ofs_y;

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      ax_in    = ax_ff;
      ay_in    = ay_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      user_in  = user_ff;
      last_in  = last_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               job_in   = job;
               state_in = BK_START;
            end
         end
         BK_START: begin
            if (load_ok) begin
               valid_in = 1'b1;
               data_in  = {job_ff.start_heading, job_ff.start_y, job_ff.start_x};
               user_in  = {job_ff.truncated, job_ff.too_close, KIND_START};
               last_in  = job_ff.too_close;
               ax_in    = {job_ff.start_x, 14'd0};
               ay_in    = {job_ff.start_y, 14'd0};
               cnt_in   = '0;
               if (job_ff.too_close) begin
                  state_in = BK_IDLE;
               end else if (job_ff.steps == '0) begin
                  state_in = BK_GOAL;
               end else begin
                  state_in = BK_MID;
               end
            end
         end
         BK_MID: begin
            if (load_ok) begin
               valid_in = 1'b1;
               data_in  = {job_ff.seg_heading, ay_next[ACC_W-1:14], ax_next[ACC_W-1:14]};
               user_in  = {job_ff.truncated, 1'b0, KIND_MID};
               last_in  = 1'b0;
               ax_in    = ax_next;
               ay_in    = ay_next;
               cnt_in   = cnt_ff + 1'b1;
               if (cnt_ff + 1'b1 == job_ff.steps) begin
                  state_in = BK_GOAL;
               end
            end
         end
         BK_GOAL: begin
            if (load_ok) begin
               valid_in = 1'b1;
               data_in  = {job_ff.goal_heading, job_ff.goal_y, job_ff.goal_x};
               user_in  = {job_ff.truncated, 1'b0, KIND_GOAL};
               last_in  = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      cnt_ff  <= cnt_in;
      data_ff <= data_in;
      user_ff <= user_in;
      last_ff <= last_in;
   end

endmodule

// ===== hw/rtl/straight_line_point_interpolator.sv =====
// Straight-line point interpolator: top level joining front end, job queue and emitter.
// Depends on slpi_pkg, slpi_front, slpi_queue and slpi_back.
//
// Usage: each beat on the req_ channel is one segment (start and goal pose). For it the
// rsp_ channel delivers the start pose, then the points spaced step_interval apart along
// the line (heading = segment heading), then the goal pose with tlast set. A segment
// shorter than the interval yields only the start pose, flagged too_close, with tlast.
// The csr_ channel writes step_interval; write it only while no segment is in flight.
// The front end runs CORDIC vectoring, removes the length gain, counts the k points,
// rotates the interval onto the segment heading for the offsets, removes their gain
// and pushes the job into the queue. The shared CORDIC rotator and the step counter
// set its pace; it takes a new segment only when idle, after the job is pushed.
// The emitter sends one point per cycle while rsp_tready is high, k + 2 per segment.
// A two-entry queue lets the front end work on the next segments while the emitter is
// stalled by rsp_tready; the output beat is held in a register until taken.
// Reset clears all control state and sets step_interval to 6554 (0.1 m).
module straight_line_point_interpolator import slpi_pkg::*; #(
   parameter int MAX_STEPS         = 62,
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // start_x, start_y, start_heading, goal_x, goal_y, goal_heading
   input  logic [159:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // point_x, point_y, point_heading
   output logic [79:0]  rsp_tdata,
   // point_kind, too_close, truncated
   output logic [3:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [30:0]  csr_data
);

   logic [30:0] step_interval_ff;
   logic        fq_valid, fq_ready, qb_valid, qb_ready;
   job_type     fq_job, qb_job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_interval_ff <= 31'd6554;
      end else if (csr_valid) begin
         step_interval_ff <= csr_data;
      end
   end

   slpi_front #(
      .MAX_STEPS         (MAX_STEPS),
      .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .seg_valid     (req_tvalid),
      .seg_ready     (req_tready),
      .seg_data      (req_tdata),
      .step_interval (step_interval_ff),
      .job_valid     (fq_valid),
      .job_ready     (fq_ready),
      .job           (fq_job)
   );

   slpi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_job   (fq_job),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_job    (qb_job)
   );

   slpi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (qb_valid),
      .job_ready  (qb_ready),
      .job        (qb_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
